// ===== sv/pgpsig_pkg.sv =====
// ----------------------------------------------------------------------------
// pgpsig_pkg
// Shared types and constants for the signature packet parser: the input and
// result words and the summary that the byte parser hands to the emitter.
// ----------------------------------------------------------------------------
package pgpsig_pkg;

  // default largest fingerprint in bytes
  localparam int unsigned FprMaxDefault = 32;
  // most fingerprint words that are ever sent
  localparam int unsigned FprWordsMax = 4;

  // version bytes and the v3 marker
  localparam logic [7:0] VersionV3 = 8'd3;
  localparam logic [7:0] VersionV4 = 8'd4;
  localparam logic [7:0] V3Marker  = 8'd5;

  // subpacket length encodings
  localparam logic [7:0] LenTwoByte  = 8'd192;
  localparam logic [7:0] LenFiveByte = 8'd255;

  // subpacket kinds that are kept
  localparam logic [6:0] KindCreated = 7'd2;
  localparam logic [6:0] KindKeyId   = 7'd16;
  localparam logic [6:0] KindFpr     = 7'd33;

  // one input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic        status;
    logic [7:0]  version;
    logic [7:0]  sig_type;
    logic [7:0]  key_algorithm;
    logic [7:0]  hash_alg;
    logic [31:0] created;
    logic        has_key_id;
    logic [63:0] key_id;
    logic [5:0]  fingerprint_len;
    logic [2:0]  word_index;
    logic [63:0] fingerprint_word;
    logic        last;
  } out_item_t;

  // packet summary at the final byte
  typedef struct packed {
    logic        status;
    logic [31:0] header;
    logic [31:0] created;
    logic        has_key_id;
    logic [63:0] key_id;
    logic [5:0]  fpr_len;
  } summary_t;

endpackage

// ===== sv/pgpsig_parser.sv =====
// ----------------------------------------------------------------------------
// pgpsig_parser
// Byte-wise parse of a signature packet body: v3 fixed layout or v4 header
// and subpacket areas. Gives the packet summary and masked fingerprint bytes
// as seen after the current byte.
// ----------------------------------------------------------------------------
module pgpsig_parser import pgpsig_pkg::*; #(
  parameter int unsigned FPR_MAX = FprMaxDefault,
  parameter int unsigned FprStore = (FPR_MAX < 32) ? FPR_MAX : 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_fire_i,
  input  in_item_t                 in_item_i,
  output summary_t                 summary_o,
  output logic [FprStore-1:0][7:0] fpr_bytes_o
);

  localparam int unsigned FprLenW = $clog2(FPR_MAX + 1);

  typedef enum logic [3:0] {
    PH_VERSION, PH_V3, PH_V4, PH_LEN1, PH_LEN2, PH_LEN4,
    PH_KIND, PH_BODY, PH_UNHLEN, PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [4:0]           pos_q, pos_d;
  logic [15:0]          area_q, area_d;
  logic [31:0]          acc_q, acc_d;
  logic [15:0]          sprem_q, sprem_d;
  logic [6:0]           kind_q, kind_d;
  logic                 aband_q, aband_d;
  logic                 unh_q, unh_d;
  logic                 malf_q, malf_d;
  logic [31:0]          header_q, header_d;
  logic [31:0]          created_q, created_d;
  logic [63:0]          keyid_q, keyid_d;
  logic                 keyok_q, keyok_d;
  logic [FprLenW-1:0]   fprlen_q, fprlen_d;
  logic [FprStore-1:0][7:0] store_q, store_d;

  logic [7:0]  b;
  logic [15:0] area_dec;
  logic [15:0] area_new;
  logic [15:0] sp_dec;
  logic [31:0] sub_len;
  logic        sub_start;
  logic [15:0] len2;
  logic [31:0] acc_shift;
  logic [6:0]  kind_in;
  logic [31:0] fidx;
  logic        enter;
  logic        enter_unh;
  logic        err;

  assign b = in_item_i.data_byte;

  // next parse state for the current byte
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    area_d    = area_q;
    acc_d     = acc_q;
    sprem_d   = sprem_q;
    kind_d    = kind_q;
    aband_d   = aband_q;
    unh_d     = unh_q;
    malf_d    = malf_q;
    header_d  = header_q;
    created_d = created_q;
    keyid_d   = keyid_q;
    keyok_d   = keyok_q;
    fprlen_d  = fprlen_q;
    store_d   = store_q;
    area_dec  = area_q - 16'd1;
    area_new  = area_q | {8'h00, b};
    sp_dec    = sprem_q - 16'd1;
    sub_len   = '0;
    sub_start = 1'b0;
    len2      = {acc_q[7:0] - LenTwoByte, 8'h00} + 16'(b) + 16'(LenTwoByte);
    acc_shift = {acc_q[23:0], b};
    kind_in   = b[6:0];
    fidx      = acc_q - 32'd1;
    enter     = 1'b0;
    enter_unh = 1'b0;

    if (pos_q != 5'h1f) begin
      pos_d = pos_q + 5'd1;
    end

    if (!malf_q) begin
      case (phase_q)
        PH_VERSION: begin
          header_d = {b, 24'h0};
          if (b == VersionV3) begin
            phase_d = PH_V3;
          end else if (b == VersionV4) begin
            phase_d = PH_V4;
          end else begin
            malf_d = 1'b1;
          end
        end
        PH_V3: begin
          if (pos_q == 5'd1) begin
            if (b != V3Marker) malf_d = 1'b1;
          end else if (pos_q == 5'd2) begin
            header_d[23:16] = b;
          end else if (pos_q <= 5'd6) begin
            created_d = {created_q[23:0], b};
          end else if (pos_q <= 5'd14) begin
            keyid_d = {keyid_q[55:0], b};
            if (pos_q == 5'd14) keyok_d = 1'b1;
          end else if (pos_q == 5'd15) begin
            header_d[15:8] = b;
          end else if (pos_q == 5'd16) begin
            header_d[7:0] = b;
          end else if (pos_q >= 5'd18) begin
            phase_d = PH_DONE;
          end
        end
        PH_V4: begin
          if (pos_q == 5'd1) begin
            header_d[23:16] = b;
          end else if (pos_q == 5'd2) begin
            header_d[15:8] = b;
          end else if (pos_q == 5'd3) begin
            header_d[7:0] = b;
          end else if (pos_q == 5'd4) begin
            area_d = {b, 8'h00};
          end else begin
            area_d = area_new;
            enter  = 1'b1;
          end
        end
        PH_UNHLEN: begin
          sprem_d = sp_dec;
          if (sp_dec == 16'd1) begin
            area_d = {b, 8'h00};
          end else begin
            area_d    = area_new;
            enter     = 1'b1;
            enter_unh = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
          // subpacket area byte
          area_d = area_dec;
          if (!aband_q) begin
            case (phase_q)
              PH_LEN1: begin
                if (b < LenTwoByte) begin
                  sub_len   = 32'(b);
                  sub_start = 1'b1;
                end else if (b < LenFiveByte) begin
                  acc_d   = 32'(b);
                  phase_d = PH_LEN2;
                end else begin
                  acc_d   = '0;
                  sprem_d = 16'd4;
                  phase_d = PH_LEN4;
                end
              end
              PH_LEN2: begin
                sub_len   = 32'(len2);
                sub_start = 1'b1;
              end
              PH_LEN4: begin
                acc_d   = acc_shift;
                sprem_d = sp_dec;
                if (sp_dec == 16'd0) begin
                  sub_len   = acc_shift;
                  sub_start = 1'b1;
                end
              end
              PH_KIND: begin
                sprem_d = sp_dec;
                kind_d  = '0;
                if (kind_in == KindCreated && sp_dec >= 16'd4) begin
                  kind_d = kind_in;
                end else if (kind_in == KindKeyId && sp_dec >= 16'd8) begin
                  kind_d = kind_in;
                end else if (kind_in == KindFpr && sp_dec >= 16'd2 &&
                             32'(sp_dec) - 32'd1 <= 32'(FPR_MAX)) begin
                  kind_d   = kind_in;
                  fprlen_d = FprLenW'(sp_dec - 16'd1);
                end
                acc_d   = '0;
                phase_d = (sp_dec == 16'd0) ? PH_LEN1 : PH_BODY;
              end
              PH_BODY: begin
                if (kind_q == KindCreated && acc_q < 32'd4) begin
                  created_d = {created_q[23:0], b};
                end else if (kind_q == KindKeyId && acc_q < 32'd8) begin
                  keyid_d = {keyid_q[55:0], b};
                  if (acc_q == 32'd7) keyok_d = 1'b1;
                end else if (kind_q == KindFpr && acc_q >= 32'd1 &&
                             fidx < 32'(FprStore)) begin
                  for (int unsigned i = 0; i < FprStore; i++) begin
                    if (fidx == 32'(i)) store_d[i] = b;
                  end
                end
                acc_d   = acc_q + 32'd1;
                sprem_d = sp_dec;
                if (sp_dec == 16'd0) phase_d = PH_LEN1;
              end
              default: begin
              end
            endcase
            // start of a subpacket body, or give up on the area
            if (sub_start) begin
              if (sub_len == 32'd0 || sub_len > 32'(area_dec)) begin
                aband_d = 1'b1;
              end else begin
                sprem_d = sub_len[15:0];
                phase_d = PH_KIND;
              end
            end
          end
          // end of the area
          if (area_dec == 16'd0) begin
            if (unh_q) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_UNHLEN;
              sprem_d = 16'd2;
            end
          end
        end
      endcase

      // entry into a subpacket area
      if (enter) begin
        unh_d   = enter_unh;
        aband_d = 1'b0;
        phase_d = PH_LEN1;
        if (area_new == 16'd0) begin
          if (enter_unh) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_UNHLEN;
            sprem_d = 16'd2;
          end
        end
      end
    end
  end

  // summary as seen after this byte
  assign err = malf_d || (phase_d != PH_DONE);

  always_comb begin
    summary_o = '0;
    summary_o.status = err;
    if (!err) begin
      summary_o.header     = header_d;
      summary_o.created    = created_d;
      summary_o.has_key_id = keyok_d;
      summary_o.key_id     = keyid_d;
      summary_o.fpr_len    = 6'(fprlen_d);
    end
    for (int unsigned i = 0; i < FprStore; i++) begin
      fpr_bytes_o[i] = (!err && i < 32'(fprlen_d)) ? store_d[i] : 8'h00;
    end
  end

  // control state, cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VERSION;
      pos_q     <= '0;
      area_q    <= '0;
      acc_q     <= '0;
      sprem_q   <= '0;
      kind_q    <= '0;
      aband_q   <= 1'b0;
      unh_q     <= 1'b0;
      malf_q    <= 1'b0;
      header_q  <= '0;
      created_q <= '0;
      keyid_q   <= '0;
      keyok_q   <= 1'b0;
      fprlen_q  <= '0;
    end else if (byte_fire_i) begin
      if (in_item_i.last_byte) begin
        phase_q   <= PH_VERSION;
        pos_q     <= '0;
        area_q    <= '0;
        acc_q     <= '0;
        sprem_q   <= '0;
        kind_q    <= '0;
        aband_q   <= 1'b0;
        unh_q     <= 1'b0;
        malf_q    <= 1'b0;
        header_q  <= '0;
        created_q <= '0;
        keyid_q   <= '0;
        keyok_q   <= 1'b0;
        fprlen_q  <= '0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        area_q    <= area_d;
        acc_q     <= acc_d;
        sprem_q   <= sprem_d;
        kind_q    <= kind_d;
        aband_q   <= aband_d;
        unh_q     <= unh_d;
        malf_q    <= malf_d;
        header_q  <= header_d;
        created_q <= created_d;
        keyid_q   <= keyid_d;
        keyok_q   <= keyok_d;
        fprlen_q  <= fprlen_d;
      end
    end
  end

  // fingerprint byte store
  always_ff @(posedge clk_i) begin
    if (byte_fire_i) begin
      store_q <= store_d;
    end
  end

endmodule

// ===== sv/pgp_signature_packet_parser.sv =====
// ----------------------------------------------------------------------------
// pgp_signature_packet_parser
// Signature packet body parser: one body byte per word in, a summary word and
// (if the packet parses) the fingerprint words out after the final byte.
// ----------------------------------------------------------------------------
// Output: the summary word is valid in the cycle after the final byte is taken.
// Throughput: one body byte per cycle; a final byte waits only while the
// previous packet's result words are still being sent (one per ready cycle).
// Reset: asynchronous, active low; clears parse state and the output queue.
module pgp_signature_packet_parser import pgpsig_pkg::*; #(
  parameter int unsigned FPR_MAX = FprMaxDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned FprStore = (FPR_MAX < 32) ? FPR_MAX : 32;
  localparam int unsigned FprWords =
    ((FPR_MAX + 7) / 8 > FprWordsMax) ? FprWordsMax : (FPR_MAX + 7) / 8;
  localparam int unsigned PadBytes = FprWords * 8;

  summary_t                 summary;
  logic [FprStore-1:0][7:0] fpr_bytes;

  logic                     snap_valid_q, snap_valid_d;
  logic [2:0]               idx_q, idx_d;
  summary_t                 snap_sum_q;
  logic [FprStore-1:0][7:0] snap_fpr_q;
  logic [PadBytes-1:0][7:0] pad_bytes;

  logic in_fire;
  logic out_fire;
  logic out_last;
  logic final_fire;

  // byte parser
  pgpsig_parser #(
    .FPR_MAX  (FPR_MAX),
    .FprStore (FprStore)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (in_fire),
    .in_item_i   (in_item_i),
    .summary_o   (summary),
    .fpr_bytes_o (fpr_bytes)
  );

  // handshakes
  assign out_last   = snap_sum_q.status || (idx_q == 3'(FprWords));
  assign out_fire   = out_valid_o && out_ready_i;
  assign in_ready_o = !in_item_i.last_byte || !snap_valid_q || (out_ready_i && out_last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign final_fire = in_fire && in_item_i.last_byte;

  // result queue control
  always_comb begin
    snap_valid_d = snap_valid_q;
    idx_d        = idx_q;
    if (out_fire) begin
      if (out_last) begin
        snap_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (final_fire) begin
      snap_valid_d = 1'b1;
      idx_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      snap_valid_q <= snap_valid_d;
      idx_q        <= idx_d;
    end
  end

  // result payload held for the packet
  always_ff @(posedge clk_i) begin
    if (final_fire) begin
      snap_sum_q <= summary;
      snap_fpr_q <= fpr_bytes;
    end
  end

  // fingerprint bytes padded to whole words
  always_comb begin
    for (int unsigned i = 0; i < PadBytes; i++) begin
      pad_bytes[i] = (i < FprStore) ? snap_fpr_q[i] : 8'h00;
    end
  end

  // result word select
  always_comb begin
    out_item_o = '0;
    if (idx_q == 3'd0) begin
      out_item_o.status          = snap_sum_q.status;
      out_item_o.version         = snap_sum_q.header[31:24];
      out_item_o.sig_type        = snap_sum_q.header[23:16];
      out_item_o.key_algorithm   = snap_sum_q.header[15:8];
      out_item_o.hash_alg        = snap_sum_q.header[7:0];
      out_item_o.created         = snap_sum_q.created;
      out_item_o.has_key_id      = snap_sum_q.has_key_id;
      out_item_o.key_id          = snap_sum_q.key_id;
      out_item_o.fingerprint_len = snap_sum_q.fpr_len;
    end else begin
      out_item_o.word_index = idx_q;
      for (int unsigned k = 0; k < FprWords; k++) begin
        if (idx_q == 3'(k + 1)) begin
          for (int unsigned j = 0; j < 8; j++) begin
            out_item_o.fingerprint_word[63 - 8*j -: 8] = pad_bytes[k*8 + j];
          end
        end
      end
    end
    out_item_o.last = out_last;
  end

  assign out_valid_o = snap_valid_q;

endmodule

// ===== bench/pgp_signature_packet_parser_tb.sv =====
// ----------------------------------------------------------------------------
// pgp_signature_packet_parser_tb
// Self-checking bench for the signature packet parser: directed packets from a
// stimulus table, then random v3/v4 packets and noise, checked word by word
// against a behavioral parser with random idling on both sides.
// ----------------------------------------------------------------------------
module pgp_signature_packet_parser_tb;
  import pgpsig_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FprMax    = FprMaxDefault;
  localparam int unsigned FprWords  = (FprMax + 7) / 8 > 4 ? 4 : (FprMax + 7) / 8;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned PosMax    = 18'h3ffff;

  typedef enum logic [3:0] {
    StVersion, StV3, StV4, StLen1, StLen2, StLen4, StKind, StBody, StUnhLen, StDone
  } parse_st_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  pgp_signature_packet_parser #(.FPR_MAX(FprMax)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser model state
  parse_st_e   st;
  int unsigned pos;
  logic [15:0] area_left;
  logic [31:0] len_acc;
  logic [15:0] sub_left;
  logic [6:0]  sub_kind;
  logic        abandoned;
  logic [31:0] hdr;
  logic [31:0] crt;
  logic [63:0] kid;
  logic        kid_ok;
  logic [5:0]  fpr_len;
  logic [7:0]  fpr_mem [FprMax];
  logic        bad;
  logic        unhashed;

  out_item_t   expected_words[$];
  int          errors = 0;
  logic        stim_done = 1'b0;
  logic        long_hold = 1'b0;

  function automatic void clear_packet();
    st = StVersion; pos = 0; area_left = '0; len_acc = '0; sub_left = '0;
    sub_kind = '0; abandoned = 1'b0; hdr = '0; crt = '0; kid = '0; kid_ok = 1'b0;
    fpr_len = '0; bad = 1'b0; unhashed = 1'b0;
  endfunction

  function automatic void open_area(logic unh);
    unhashed = unh;
    abandoned = 1'b0;
    st = StLen1;
    if (area_left == 0) begin
      if (unh) begin
        st = StDone;
      end else begin
        st = StUnhLen;
        sub_left = 16'd2;
      end
    end
  endfunction

  function automatic void open_subpacket(logic [31:0] len);
    if (len == 0 || len > area_left) begin
      abandoned = 1'b1;
    end else begin
      sub_left = len[15:0];
      st = StKind;
    end
  endfunction

  // subpacket area byte
  function automatic void area_step(logic [7:0] b);
    logic [31:0] size;
    logic [6:0]  k;
    logic [31:0] idx;
    area_left = area_left - 1'b1;
    if (!abandoned) begin
      case (st)
        StLen1: begin
          if (b < LenTwoByte) begin
            open_subpacket({24'd0, b});
          end else if (b < LenFiveByte) begin
            len_acc = {24'd0, b};
            st = StLen2;
          end else begin
            len_acc = '0;
            sub_left = 16'd4;
            st = StLen4;
          end
        end
        StLen2: begin
          open_subpacket(((len_acc - 32'd192) << 8) + b + 32'd192);
        end
        StLen4: begin
          len_acc = (len_acc << 8) | b;
          sub_left = sub_left - 1'b1;
          if (sub_left == 0) open_subpacket(len_acc);
        end
        StKind: begin
          k = b[6:0];
          sub_left = sub_left - 1'b1;
          size = {16'd0, sub_left};
          sub_kind = '0;
          if (k == KindCreated && size >= 4) begin
            sub_kind = k;
          end else if (k == KindKeyId && size >= 8) begin
            sub_kind = k;
          end else if (k == KindFpr && size >= 2 && size - 1 <= FprMax) begin
            sub_kind = k;
            fpr_len = 6'(size - 1);
          end
          len_acc = '0;
          st = (sub_left == 0) ? StLen1 : StBody;
        end
        StBody: begin
          idx = len_acc;
          if (sub_kind == KindCreated && idx < 4) begin
            crt = (crt << 8) | b;
          end else if (sub_kind == KindKeyId && idx < 8) begin
            kid = (kid << 8) | b;
            if (idx == 7) kid_ok = 1'b1;
          end else if (sub_kind == KindFpr && idx >= 1 && idx - 1 < FprMax) begin
            fpr_mem[idx - 1] = b;
          end
          len_acc = len_acc + 1;
          sub_left = sub_left - 1'b1;
          if (sub_left == 0) st = StLen1;
        end
        default: ;
      endcase
    end
    if (area_left == 0) begin
      if (unhashed) begin
        st = StDone;
      end else begin
        st = StUnhLen;
        sub_left = 16'd2;
      end
    end
  endfunction

  // one accepted byte: update the model and queue any result words
  function automatic void parse_byte(in_item_t it);
    logic [7:0]  b;
    int unsigned p;
    out_item_t   w;
    b = it.data_byte;
    p = pos;
    if (pos < PosMax) pos++;
    if (!bad) begin
      case (st)
        StVersion: begin
          hdr = {b, 24'd0};
          if (b == VersionV3) st = StV3;
          else if (b == VersionV4) st = StV4;
          else bad = 1'b1;
        end
        StV3: begin
          if (p == 1) begin
            if (b != V3Marker) bad = 1'b1;
          end else if (p == 2) hdr[23:16] = b;
          else if (p <= 6) crt = (crt << 8) | b;
          else if (p <= 14) begin
            kid = (kid << 8) | b;
            if (p == 14) kid_ok = 1'b1;
          end else if (p == 15) hdr[15:8] = b;
          else if (p == 16) hdr[7:0] = b;
          else if (p >= 18) st = StDone;
        end
        StV4: begin
          if (p == 1) hdr[23:16] = b;
          else if (p == 2) hdr[15:8] = b;
          else if (p == 3) hdr[7:0] = b;
          else if (p == 4) area_left = {b, 8'd0};
          else begin
            area_left[7:0] = b;
            open_area(1'b0);
          end
        end
        StUnhLen: begin
          sub_left = sub_left - 1'b1;
          if (sub_left == 1) area_left = {b, 8'd0};
          else begin
            area_left[7:0] = b;
            open_area(1'b1);
          end
        end
        StDone: ;
        default: area_step(b);
      endcase
    end
    if (!it.last_byte) return;
    w = '0;
    if (bad || st != StDone) begin
      w.status = 1'b1;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      {w.version, w.sig_type, w.key_algorithm, w.hash_alg} = hdr;
      w.created = crt;
      w.has_key_id = kid_ok;
      w.key_id = kid;
      w.fingerprint_len = fpr_len;
      w.last = (FprWords == 0);
      expected_words.push_back(w);
      for (int k = 1; k <= FprWords; k++) begin
        w = '0;
        w.word_index = 3'(k);
        for (int j = 0; j < 8; j++) begin
          w.fingerprint_word = w.fingerprint_word << 8;
          if ((k - 1) * 8 + j < fpr_len) w.fingerprint_word[7:0] = fpr_mem[(k - 1) * 8 + j];
        end
        w.last = (k == FprWords);
        expected_words.push_back(w);
      end
    end
    clear_packet();
  endfunction

  // byte stream to send
  in_item_t byte_q[$];

  task automatic put(logic [7:0] b, logic fin = 1'b0);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = fin;
    byte_q.push_back(it);
  endtask

  // subpacket with a one, two or five byte length
  task automatic put_subpacket(logic [7:0] kind, int unsigned body_len, int unsigned enc);
    int unsigned n;
    n = body_len + 1;
    if (enc == 0 && n < 192) put(8'(n));
    else if (enc != 2 && n < 8384) begin
      put(8'(((n - 192) >> 8) + 192));
      put(8'(n - 192));
    end else begin
      put(8'd255);
      put(8'(n >> 24)); put(8'(n >> 16)); put(8'(n >> 8)); put(8'(n));
    end
    put(kind);
    for (int i = 0; i < body_len; i++) put(8'($urandom));
  endtask

  // the two size bytes, then random area contents as a list of subpackets
  task automatic put_area(logic broken);
    in_item_t body[$];
    in_item_t saved[$];
    int unsigned nsub;
    int unsigned kinds[4];
    int unsigned kind;
    int unsigned blen;
    kinds = '{2, 16, 33, 0};
    saved = byte_q;
    byte_q = {};
    nsub = $urandom_range(0, 3);
    for (int s = 0; s < nsub; s++) begin
      kind = kinds[$urandom_range(0, 3)];
      if (kind == 0) kind = $urandom_range(0, 255);
      else if ($urandom_range(0, 1)) kind = kind | 8'h80;
      case (kind & 8'h7f)
        2:  blen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4;
        16: blen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 8;
        33: blen = $urandom_range(0, 3) == 0 ? $urandom_range(0, FprMax + 3)
                                            : $urandom_range(1, 2) * 10 + 1;
        default: blen = $urandom_range(0, 6);
      endcase
      put_subpacket(8'(kind), blen, $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0);
    end
    if (broken) begin
      case ($urandom_range(0, 2))
        0: put(8'd0);
        1: put(8'd100);
        default: put(8'd255);
      endcase
      put(8'($urandom));
    end
    body = byte_q;
    byte_q = saved;
    put(8'(body.size() >> 8));
    put(8'(body.size()));
    foreach (body[i]) byte_q.push_back(body[i]);
  endtask

  // one random packet: mostly well formed, some truncated or noisy
  task automatic put_random_packet();
    int unsigned kind;
    int unsigned start;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    start = byte_q.size();
    if (kind == 9) begin
      repeat ($urandom_range(0, 6)) put(8'($urandom));
    end else if (kind <= 1) begin
      put(VersionV3);
      put($urandom_range(0, 7) == 0 ? 8'($urandom) : V3Marker);
      repeat (16) put(8'($urandom));
      repeat ($urandom_range(0, 2)) put(8'($urandom));
    end else begin
      put(VersionV4);
      repeat (3) put(8'($urandom));
      put_area($urandom_range(0, 5) == 0);
      put_area($urandom_range(0, 5) == 0);
      repeat ($urandom_range(0, 2)) put(8'($urandom));
    end
    if (byte_q.size() == start) put(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(start, byte_q.size() - 1);
      while (byte_q.size() > cut + 1) void'(byte_q.pop_back());
    end
    byte_q[byte_q.size() - 1].last_byte = 1'b1;
  endtask

  // directed packets: a stimulus table of bytes with the summary read off
  typedef struct {
    logic [7:0] bytes[$];
    logic       known;
    out_item_t  summary;
  } dir_row_t;

  dir_row_t dir_rows[$];
  out_item_t dir_summary[$];

  task automatic build_directed();
    dir_row_t r;
    out_item_t e;
    // unknown version
    e = '0; e.status = 1'b1; e.last = 1'b1;
    r.bytes = '{8'd0}; r.known = 1; r.summary = e; dir_rows.push_back(r);
    r.bytes = '{8'd255}; dir_rows.push_back(r);
    // bad v3 marker
    r.bytes = '{VersionV3, 8'd4, 8'd0}; dir_rows.push_back(r);
    // truncated v4 header
    r.bytes = '{VersionV4, 8'h10, 8'h01}; dir_rows.push_back(r);
    // v4 empty areas, all ones header
    e = '0; e.version = VersionV4; e.sig_type = 8'hff; e.key_algorithm = 8'hff;
    e.hash_alg = 8'hff;
    r.bytes = '{VersionV4, 8'hff, 8'hff, 8'hff, 8'd0, 8'd0, 8'd0, 8'd0};
    r.summary = e; dir_rows.push_back(r);
    // v3 all ones
    e = '0; e.version = VersionV3; e.sig_type = 8'hff; e.created = '1;
    e.has_key_id = 1'b1; e.key_id = '1; e.key_algorithm = 8'hff; e.hash_alg = 8'hff;
    r.bytes = '{VersionV3, V3Marker, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
    r.summary = e; dir_rows.push_back(r);
    // v3 one byte short
    e = '0; e.status = 1'b1; e.last = 1'b1;
    r.bytes.delete(r.bytes.size() - 1); r.summary = e; dir_rows.push_back(r);
    // v4 with a zero-length subpacket in the hashed area, unhashed missing
    r.bytes = '{VersionV4, 8'h00, 8'h01, 8'h08, 8'h00, 8'h02, 8'h00, 8'h55};
    r.summary = e; dir_rows.push_back(r);
    // v4 created + key id, second created overrides, five byte length
    e = '0; e.version = VersionV4; e.sig_type = 8'h13; e.key_algorithm = 8'h01;
    e.hash_alg = 8'h08; e.created = 32'h89abcdef; e.has_key_id = 1'b1;
    e.key_id = 64'h0102030405060708;
    r.bytes = '{VersionV4, 8'h13, 8'h01, 8'h08, 8'h00, 8'd16,
                8'd5, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01,
                8'd255, 8'h00, 8'h00, 8'h00, 8'h05, 8'h82, 8'h89, 8'hab, 8'hcd, 8'hef,
                8'h00, 8'd10, 8'd9, 8'h10, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                8'h07, 8'h08};
    r.summary = e; dir_rows.push_back(r);
    // fingerprints of one below and at the largest size; and a two byte length
    r.known = 0;
    r.bytes = '{VersionV4, 8'h00, 8'h16, 8'h0a, 8'h00, 8'd34, 8'd33, 8'h21, 8'h04};
    for (int i = 0; i < 32; i++) r.bytes.push_back(8'(8'hf0 ^ i));
    r.bytes.push_back(8'h00); r.bytes.push_back(8'h00);
    dir_rows.push_back(r);
    r.bytes = '{VersionV4, 8'h00, 8'h16, 8'h0a, 8'h00, 8'd35, 8'd34, 8'h21, 8'h04};
    for (int i = 0; i < 33; i++) r.bytes.push_back(8'($urandom));
    r.bytes.push_back(8'h00); r.bytes.push_back(8'h00);
    dir_rows.push_back(r);
    r.bytes = '{VersionV4, 8'h00, 8'h16, 8'h0a, 8'h00, 8'd23, 8'd192, 8'd20, 8'h21, 8'h04};
    for (int i = 0; i < 20; i++) r.bytes.push_back(8'(i));
    r.bytes.push_back(8'h00); r.bytes.push_back(8'h00); r.bytes.push_back(8'h77);
    dir_rows.push_back(r);
  endtask

  // sender
  int unsigned accepted_in = 0;
  initial begin
    in_item_t    it;
    int unsigned idle;
    in_valid_i = 1'b0;
    in_item_i = '0;
    rst_ni = 1'b0;
    clear_packet();
    build_directed();
    foreach (dir_rows[i]) begin
      foreach (dir_rows[i].bytes[j]) put(dir_rows[i].bytes[j], j == dir_rows[i].bytes.size() - 1);
      if (dir_rows[i].known) dir_summary.push_back(dir_rows[i].summary);
    end
    while (byte_q.size() < 450) put_random_packet();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (byte_q.size() > 0) begin
      it = byte_q.pop_front();
      idle = long_hold ? 0 : $urandom_range(0, 12);
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i <= it;
      do @(posedge clk_i); while (!in_ready_o);
      parse_byte(it);
      accepted_in++;
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off early on
  int unsigned accepted_out = 0;
  initial begin
    int unsigned idle;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    repeat (40) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
    forever begin
      idle = $urandom_range(0, 12);
      if (idle > 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // checker
  always @(posedge clk_i) begin
    out_item_t e;
    out_item_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a = out_item_o;
      accepted_out++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", a);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (a.word_index == 0 && dir_summary.size() > 0) begin
          if (dir_summary[0] != e) begin
            $error("table summary %h disagrees with prediction %h", dir_summary[0], e);
            errors++;
          end
          void'(dir_summary.pop_front());
        end
        if (a.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, a.status); errors++; end
        if (a.version !== e.version) begin
          $error("version: expected %0d actual %0d", e.version, a.version); errors++; end
        if (a.sig_type !== e.sig_type) begin
          $error("sig_type: expected %0d actual %0d", e.sig_type,
                 a.sig_type); errors++; end
        if (a.key_algorithm !== e.key_algorithm) begin
          $error("key_algorithm: expected %0d actual %0d", e.key_algorithm,
                 a.key_algorithm); errors++; end
        if (a.hash_alg !== e.hash_alg) begin
          $error("hash_alg: expected %0d actual %0d", e.hash_alg,
                 a.hash_alg); errors++; end
        if (a.created !== e.created) begin
          $error("created: expected %h actual %h", e.created, a.created); errors++; end
        if (a.has_key_id !== e.has_key_id) begin
          $error("has_key_id: expected %0d actual %0d", e.has_key_id, a.has_key_id);
          errors++; end
        if (a.key_id !== e.key_id) begin
          $error("key_id: expected %h actual %h", e.key_id, a.key_id); errors++; end
        if (a.fingerprint_len !== e.fingerprint_len) begin
          $error("fingerprint_len: expected %0d actual %0d", e.fingerprint_len,
                 a.fingerprint_len); errors++; end
        if (a.word_index !== e.word_index) begin
          $error("word_index: expected %0d actual %0d", e.word_index, a.word_index);
          errors++; end
        if (a.fingerprint_word !== e.fingerprint_word) begin
          $error("fingerprint_word: expected %h actual %h", e.fingerprint_word,
                 a.fingerprint_word); errors++; end
        if (a.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, a.last); errors++; end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int unsigned quiet;
    int unsigned seen_in;
    int unsigned seen_out;
    quiet = 0;
    seen_in = 0;
    seen_out = 0;
    @(posedge rst_ni);
    while (!(stim_done && expected_words.size() == 0) && quiet < IdleLimit) begin
      @(posedge clk_i);
      if (accepted_in != seen_in || accepted_out != seen_out) quiet = 0;
      else quiet++;
      seen_in = accepted_in;
      seen_out = accepted_out;
    end
    if (quiet >= IdleLimit) begin
      $display("end of test: mismatches");
    end else begin
      repeat (20) @(posedge clk_i);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
